[rtl/core/prtt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_pkg
// Types and constants shared by the pending reply timeout table.
// ----------------------------------------------------------------------------
package prtt_pkg;

  localparam int unsigned ENTRIES_DEF   = 10;
  localparam int unsigned ADDR_W        = 2;
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT = ADDR_W'(0);
  localparam logic [31:0] TIMEOUT_RESET = 32'd24;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_REPLY = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_RECORDED = 3'd0,
    ST_PENDING  = 3'd1,
    ST_FULL     = 3'd2,
    ST_CLEARED  = 3'd3,
    ST_EXPIRED  = 3'd4,
    ST_NONE     = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [30:0] peer_id;
    logic [31:0] current_time;
    logic        is_player;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] expired_peer;
    logic        last;
  } out_item_t;

  // Transaction token walking the cell chain.
  typedef struct packed {
    logic        valid;
    op_e         op;
    logic [30:0] peer;
    logic [31:0] now;
    logic        dup;
    logic        claimed;
    logic        hit;
    logic        have_held;
    logic [30:0] held_peer;
  } tok_t;

  // End-of-walk broadcast that settles a tentative send.
  typedef struct packed {
    logic fin;
    logic cancel;
  } commit_t;

  // Request from a cell to push a held expiry out.
  typedef struct packed {
    logic        req;
    logic [30:0] peer;
  } emit_t;

endpackage

[rtl/core/prtt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_cell
// One table slot plus the token stage that hands the transaction onward.
// ----------------------------------------------------------------------------
module prtt_cell
  import prtt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  logic [31:0] timeout_i,
  input  commit_t     commit_i,
  input  tok_t        tok_i,
  output tok_t        tok_o,
  output emit_t       emit_o
);

  logic [30:0] peer_q, peer_d;
  logic [31:0] time_q, time_d;
  logic        tent_q, tent_d;
  tok_t        tok_q, tok_d;

  logic        occupied;
  logic        match;
  logic        expired;
  logic [31:0] elapsed;

  assign occupied = (peer_q != 31'd0);
  assign match    = occupied && (peer_q == tok_i.peer);
  assign elapsed  = tok_i.now - time_q;
  assign expired  = occupied && (elapsed > timeout_i);

  always_comb begin
    tok_d  = tok_i;
    peer_d = peer_q;
    time_d = time_q;
    tent_d = tent_q;
    emit_o = '0;
    if (tok_i.valid) begin
      unique case (tok_i.op)
        OP_SEND: begin
          if (match) begin
            tok_d.dup = 1'b1;
          end else if (!occupied && !tok_i.claimed && !tok_i.dup) begin
            // first free slot: write now, undo at end if a duplicate shows up
            tok_d.claimed = 1'b1;
            if (advance_i) begin
              peer_d = tok_i.peer;
              time_d = tok_i.now;
              tent_d = 1'b1;
            end
          end
        end
        OP_REPLY: begin
          if (match) begin
            tok_d.hit = 1'b1;
            if (advance_i) begin
              peer_d = 31'd0;
              time_d = 32'd0;
            end
          end
        end
        OP_CHECK: begin
          if (expired) begin
            emit_o.req     = tok_i.have_held;
            emit_o.peer    = tok_i.held_peer;
            tok_d.have_held = 1'b1;
            tok_d.held_peer = peer_q;
            if (advance_i) begin
              peer_d = 31'd0;
              time_d = 32'd0;
            end
          end
        end
        OP_NONE: begin
        end
      endcase
    end
    if (commit_i.fin) begin
      tent_d = 1'b0;
      if (commit_i.cancel && tent_q) begin
        peer_d = 31'd0;
        time_d = 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_q <= '0;
      time_q <= '0;
      tent_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      peer_q <= peer_d;
      time_q <= time_d;
      tent_q <= tent_d;
      if (advance_i) begin
        tok_q <= tok_d;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

[rtl/core/prtt_apb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_apb
// APB register slave holding the expiry timeout.
// ----------------------------------------------------------------------------
module prtt_apb
  import prtt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [31:0]       timeout_o
);

  logic [31:0] timeout_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_TIMEOUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (wr_en) begin
      timeout_q <= pwdata;
    end
  end

  assign prdata    = (paddr == ADDR_TIMEOUT) ? timeout_q : 32'd0;
  assign timeout_o = timeout_q;

endmodule

[rtl/core/pending_reply_timeout_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_reply_timeout_table_top
// Table of peers awaiting a reply, with send, reply and expiry check.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Payload
//  --------  ---------  ---------------------------  -------------------
//  in        input      in_valid_i / in_stall_o      in_item_t
//  out       output     out_valid_o / out_stall_i    out_item_t
//  cfg       input      APB psel/penable/pready      timeout register
//
//  Each transaction walks a chain of ENTRIES cells, one cell per cycle while
//  not frozen, and settles as it leaves the last cell: its result is pushed
//  and the commit settles a tentative send; only then is a new item taken.
//  A stalled output freezes the walk wherever a result must be pushed. Reset
//  empties every slot at once (per-cell flops); the timeout resets to 24.
//
module pending_reply_timeout_table_top
  import prtt_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] timeout;

  prtt_apb u_apb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .timeout_o (timeout)
  );

  // Token chain: stage 0 is the input register, stage g+1 is cell g's output.
  tok_t    tok_w  [ENTRIES+1];
  emit_t   emit_w [ENTRIES];
  tok_t    in_tok_q, in_tok_d;
  commit_t commit;
  logic    advance;
  logic    busy;
  logic    in_accept;
  logic    emit_req;
  logic [30:0] emit_peer;
  logic    fin_req;
  logic    out_free;
  logic    push;

  out_item_t out_q, out_d;
  logic      out_valid_q;

  assign tok_w[0] = in_tok_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    prtt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .timeout_i (timeout),
      .commit_i  (commit),
      .tok_i     (tok_w[g]),
      .tok_o     (tok_w[g+1]),
      .emit_o    (emit_w[g])
    );
  end

  // Only one transaction is ever in the chain, so these reduce a one-hot set.
  always_comb begin
    busy      = 1'b0;
    emit_req  = 1'b0;
    emit_peer = 31'd0;
    for (int i = 0; i <= ENTRIES; i++) begin
      busy = busy | tok_w[i].valid;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      emit_req  = emit_req | emit_w[i].req;
      emit_peer = emit_peer | (emit_w[i].req ? emit_w[i].peer : 31'd0);
    end
  end

  assign fin_req   = tok_w[ENTRIES].valid;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign push      = out_free && (emit_req || fin_req);
  // walk holds only while a result waits for room in the output register
  assign advance   = out_free || !(emit_req || fin_req);
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;

  assign commit.fin    = push && fin_req;
  assign commit.cancel = (tok_w[ENTRIES].op == OP_SEND) && tok_w[ENTRIES].dup;

  // Non-players, the unused opcode and a send of peer 0 reduce to a no-op.
  always_comb begin
    in_tok_d = in_tok_q;
    if (in_accept) begin
      in_tok_d       = '0;
      in_tok_d.valid = 1'b1;
      in_tok_d.peer  = in_item_i.peer_id;
      in_tok_d.now   = in_item_i.current_time;
      in_tok_d.op    = op_e'(in_item_i.operation);
      if (!in_item_i.is_player ||
          ((op_e'(in_item_i.operation) == OP_SEND) && (in_item_i.peer_id == 31'd0))) begin
        in_tok_d.op = OP_NONE;
      end
    end else if (advance) begin
      in_tok_d.valid = 1'b0;
    end
  end

  // Result selection: a held expiry pushed mid-walk, or the closing result.
  always_comb begin
    out_d = out_q;
    if (emit_req) begin
      out_d.status       = ST_EXPIRED;
      out_d.expired_peer = emit_peer;
      out_d.last         = 1'b0;
    end else begin
      out_d.expired_peer = 31'd0;
      out_d.last         = 1'b1;
      unique case (tok_w[ENTRIES].op)
        OP_SEND: begin
          if (tok_w[ENTRIES].dup) begin
            out_d.status = ST_PENDING;
          end else if (tok_w[ENTRIES].claimed) begin
            out_d.status = ST_RECORDED;
          end else begin
            out_d.status = ST_FULL;
          end
        end
        OP_REPLY: begin
          out_d.status = tok_w[ENTRIES].hit ? ST_CLEARED : ST_NONE;
        end
        OP_CHECK: begin
          if (tok_w[ENTRIES].have_held) begin
            out_d.status       = ST_EXPIRED;
            out_d.expired_peer = tok_w[ENTRIES].held_peer;
          end else begin
            out_d.status = ST_NONE;
          end
        end
        OP_NONE: begin
          out_d.status = ST_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tok_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_tok_q <= in_tok_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
